>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted list: holds a value, compares it with the value
// being pushed and shifts towards the tail on a push or the head on a pop.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                      clk,
  input  spq_pkg::cell_cmd_t        cmd,
  input  logic                      occupied,
  input  logic                      prev_keep,
  input  logic [spq_pkg::DATA_W-1:0] prev_data,
  input  logic [spq_pkg::DATA_W-1:0] next_data,
  output logic                      keep,
  output logic [spq_pkg::DATA_W-1:0] data
);

  logic [spq_pkg::DATA_W-1:0] data_r;
  logic [spq_pkg::DATA_W-1:0] data_nxt;

  assign keep = occupied && ($signed(data_r) > $signed(cmd.value));
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (cmd.push) begin
      priority if (keep) begin
        data_nxt = data_r;
      end else if (prev_keep) begin
        data_nxt = cmd.value;
      end else begin
        data_nxt = prev_data;
      end
    end else if (cmd.pop) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-priority queue kept in descending order in a row of cells.
// ----------------------------------------------------------------------------
// The result strobe is registered and follows in the cycle after start is taken.
// Throughput: one item per cycle; all cells compare and shift in parallel.
// busy stays low, so start may be held high on consecutive cycles.
// Reset empties the queue and clears the strobe; cell contents are not reset.
// Results cannot be stalled by the receiver.
module sorted_priority_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic signed [spq_pkg::DATA_W-1:0] in_value,
  output logic                           out_valid,
  output logic signed [spq_pkg::DATA_W-1:0] out_head_value,
  output logic signed [spq_pkg::DATA_W-1:0] out_tail_value,
  output logic [spq_pkg::OUT_CNT_W-1:0]  out_count,
  output logic [1:0]                     out_status
);

  localparam int Cap = spq_pkg::CAPACITY;

  logic                        accept;
  logic                        is_full;
  logic                        is_empty;
  spq_pkg::cell_cmd_t          cmd;
  logic [Cap:0]                keep_c;
  logic [spq_pkg::DATA_W-1:0]  data_c [Cap+1];

  logic [spq_pkg::CNT_W-1:0]   count_r;
  logic [spq_pkg::CNT_W-1:0]   count_nxt;
  logic [spq_pkg::DATA_W-1:0]  tail_r;
  logic [spq_pkg::DATA_W-1:0]  tail_nxt;
  spq_pkg::status_t            status_r;
  spq_pkg::status_t            status_nxt;
  logic                        valid_r;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == spq_pkg::CNT_W'(Cap));
  assign is_empty = (count_r == '0);

  always_comb begin
    cmd.value = in_value;
    cmd.push  = accept && (in_operation == spq_pkg::OP_PUSH) && !is_full;
    cmd.pop   = accept && (in_operation == spq_pkg::OP_POP) && !is_empty;
  end

  assign keep_c[0]   = 1'b1;
  assign data_c[Cap] = '0;

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic [spq_pkg::DATA_W-1:0] prev_d;
    if (i == 0) begin : g_first
      assign prev_d = in_value;
    end else begin : g_rest
      assign prev_d = data_c[i-1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (spq_pkg::CNT_W'(i) < count_r),
      .prev_keep (keep_c[i]),
      .prev_data (prev_d),
      .next_data (data_c[i+1]),
      .keep      (keep_c[i+1]),
      .data      (data_c[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    tail_nxt   = tail_r;
    status_nxt = status_r;
    if (accept) begin
      unique case (in_operation)
        spq_pkg::OP_PUSH: begin
          if (is_full) begin
            status_nxt = spq_pkg::ST_FULL;
          end else begin
            status_nxt = spq_pkg::ST_OK;
            count_nxt  = count_r + spq_pkg::CNT_W'(1);
            if (is_empty || ($signed(in_value) < $signed(tail_r))) begin
              tail_nxt = in_value;
            end
          end
        end
        spq_pkg::OP_POP: begin
          if (is_empty) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            status_nxt = spq_pkg::ST_OK;
            count_nxt  = count_r - spq_pkg::CNT_W'(1);
          end
        end
        default: status_nxt = status_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      valid_r  <= 1'b0;
      status_r <= spq_pkg::ST_OK;
    end else begin
      count_r  <= count_nxt;
      valid_r  <= accept;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
  end

  assign out_valid      = valid_r;
  assign out_head_value = is_empty ? '0 : $signed(data_c[0]);
  assign out_tail_value = is_empty ? '0 : $signed(tail_r);
  assign out_count      = spq_pkg::OUT_CNT_W'(count_r);
  assign out_status     = status_r;

  a_strobe_follows_start: assert property (
    @(posedge clk) disable iff (!rst_n) accept |=> out_valid
  ) else $error("result strobe missing after accepted item");

  a_no_spurious_strobe: assert property (
    @(posedge clk) disable iff (!rst_n) !accept |=> !out_valid
  ) else $error("result strobe without accepted item");

  a_count_bounded: assert property (
    @(posedge clk) disable iff (!rst_n) count_r <= spq_pkg::CNT_W'(Cap)
  ) else $error("entry count beyond capacity");

  a_full_holds_count: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_valid && (status_r == spq_pkg::ST_FULL) |-> is_full
  ) else $error("full status with spare capacity");

  a_head_not_below_tail: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_valid && !is_empty |-> ($signed(data_c[0]) >= $signed(tail_r))
  ) else $error("head below tail");

  a_empty_reject_keeps_empty: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_valid && (status_r == spq_pkg::ST_EMPTY) |-> is_empty
  ) else $error("empty status with stored entries");

endmodule

>>> dv/sorted_priority_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Drives pushes and pops into the sorted priority queue and checks every
// result strobe (head, tail, count, status) against a behavioural mirror of
// the queue. Covers pops on empty, pushes on full, equal values and the
// extremes of the signed value range, then long random runs with bursty
// traffic and a shifting push/pop balance.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

  localparam int IDLE_LIMIT = 400;
  localparam logic signed [spq_pkg::DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [spq_pkg::DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

  typedef struct {
    logic signed [spq_pkg::DATA_W-1:0] head;
    logic signed [spq_pkg::DATA_W-1:0] tail;
    logic [spq_pkg::OUT_CNT_W-1:0]     count;
    spq_pkg::status_t                  status;
  } queue_report_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              in_operation = 1'b0;
  logic signed [spq_pkg::DATA_W-1:0] in_value = '0;
  logic                              busy;
  logic                              out_valid;
  logic signed [spq_pkg::DATA_W-1:0] out_head_value;
  logic signed [spq_pkg::DATA_W-1:0] out_tail_value;
  logic [spq_pkg::OUT_CNT_W-1:0]     out_count;
  logic [1:0]                        out_status;

  logic signed [spq_pkg::DATA_W-1:0] mirror_entries[$];
  queue_report_t                     expected_reports[$];
  int                                mismatches = 0;
  int                                burst_left = 0;
  int                                idle_cycles = 0;

  always #10 clk = ~clk;

  sorted_priority_queue uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_head_value (out_head_value),
    .out_tail_value (out_tail_value),
    .out_count      (out_count),
    .out_status     (out_status)
  );

  function automatic queue_report_t predict_queue_op(spq_pkg::op_t op,
                                                     logic signed [spq_pkg::DATA_W-1:0] v);
    queue_report_t rep;
    int            pos;
    rep.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_PUSH) begin
      if (mirror_entries.size() >= spq_pkg::CAPACITY) begin
        rep.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < mirror_entries.size() && mirror_entries[pos] > v) pos++;
        mirror_entries.insert(pos, v);
      end
    end else if (mirror_entries.size() == 0) begin
      rep.status = spq_pkg::ST_EMPTY;
    end else begin
      void'(mirror_entries.pop_front());
    end
    rep.head  = (mirror_entries.size() > 0) ? mirror_entries[0] : '0;
    rep.tail  = (mirror_entries.size() > 0) ? mirror_entries[mirror_entries.size() - 1] : '0;
    rep.count = spq_pkg::OUT_CNT_W'(mirror_entries.size());
    return rep;
  endfunction

  function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
    int r;
    case ($urandom_range(0, 3))
      0: begin
        r = $urandom_range(0, 8);
        return r - 4;
      end
      1: begin
        case ($urandom_range(0, 3))
          0: return MAX_VAL;
          1: return MIN_VAL;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(spq_pkg::op_t op, logic signed [spq_pkg::DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        start        <= 1'b0;
        in_operation <= 1'($urandom_range(0, 1));
        in_value     <= $urandom;
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_reports.push_back(predict_queue_op(op, v));
    burst_left--;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    burst_left = 0;
  endtask

  task automatic test_pop_on_empty();
    send_item(spq_pkg::OP_POP, MAX_VAL);
    send_item(spq_pkg::OP_POP, MIN_VAL);
  endtask

  task automatic test_value_extremes();
    send_item(spq_pkg::OP_PUSH, MAX_VAL);
    send_item(spq_pkg::OP_PUSH, MIN_VAL);
    send_item(spq_pkg::OP_PUSH, '0);
    send_item(spq_pkg::OP_PUSH, -1);
    send_item(spq_pkg::OP_PUSH, 1);
    repeat (6) send_item(spq_pkg::OP_POP, '0);
  endtask

  task automatic test_equal_values();
    send_item(spq_pkg::OP_PUSH, 5);
    send_item(spq_pkg::OP_PUSH, 5);
    send_item(spq_pkg::OP_PUSH, 7);
    send_item(spq_pkg::OP_PUSH, 5);
    send_item(spq_pkg::OP_PUSH, -5);
    send_item(spq_pkg::OP_PUSH, -5);
    repeat (3) send_item(spq_pkg::OP_POP, '0);
  endtask

  task automatic test_fill_and_overflow(int rounds);
    int  n_ops;
    bit  narrow;
    logic signed [spq_pkg::DATA_W-1:0] v;
    for (int r = 0; r < rounds; r++) begin
      narrow = $urandom_range(0, 1);
      n_ops  = spq_pkg::CAPACITY + $urandom_range(1, 3);
      repeat (n_ops) begin
        v = narrow ? (pick_value() & 32'sh0000_0003) : pick_value();
        send_item(spq_pkg::OP_PUSH, v);
      end
      n_ops = spq_pkg::CAPACITY + $urandom_range(1, 3);
      repeat (n_ops) send_item(spq_pkg::OP_POP, $urandom);
    end
  endtask

  task automatic test_random_mix(int n_items);
    int           push_pct;
    spq_pkg::op_t op;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) push_pct = $urandom_range(20, 80);
      if (i == n_items / 2) wait_drained();
      op = ($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
      send_item(op, pick_value());
    end
  endtask

  always @(posedge clk) begin : result_check
    queue_report_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result: head %0d tail %0d count %0d status %0d",
               out_head_value, out_tail_value, out_count, out_status);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (out_head_value !== want.head) begin
          $error("head_value: expected %0d, got %0d", want.head, out_head_value);
          mismatches++;
        end
        if (out_tail_value !== want.tail) begin
          $error("tail_value: expected %0d, got %0d", want.tail, out_tail_value);
          mismatches++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("sorted_priority_queue_test: FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_pop_on_empty();
    test_value_extremes();
    test_equal_values();
    wait_drained();
    test_fill_and_overflow(12);
    wait_drained();
    test_random_mix(1400);
    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d results never arrived", expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("sorted_priority_queue_test: PASS");
    end else begin
      $display("sorted_priority_queue_test: FAIL");
    end
    $finish;
  end

endmodule
